// ===== hdl/fwk_pkg.sv =====
// fwk_pkg: shared types and constants for the binary indexed tree block
// beat payload structs, action codes, sequencer states and adder request/response
// no dependencies
`default_nettype none

package fwk_pkg;

    localparam int POS_W  = 13;
    localparam int DATA_W = 32;
    localparam int RANK_W = 31;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_PREFIX = 2'd1,
        ACT_RANGE  = 2'd2,
        ACT_FIND   = 2'd3
    } fwk_action_t;

    typedef struct packed {
        fwk_action_t               action;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          right_end;
        logic signed [DATA_W-1:0]  delta;
        logic [RANK_W-1:0]         rank;
    } fwk_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  sum_value;
        logic [POS_W-1:0]          found_position;
    } fwk_result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_FIND_RD,
        ST_FIND_EVAL,
        ST_DONE
    } fwk_state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } fwk_alu_op_t;

    typedef struct packed {
        fwk_alu_op_t        op;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [RANK_W-1:0]  rank;
    } fwk_alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  sum;
        logic               below_rank;
    } fwk_alu_res_t;

endpackage

`default_nettype wire

// ===== hdl/fwk_ram.sv =====
// fwk_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module fwk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/fwk_alu.sv =====
// fwk_alu: shared 32-bit add/subtract unit with signed compare against a rank
// depends on fwk_pkg
`default_nettype none

module fwk_alu (
    input  wire fwk_pkg::fwk_alu_req_t req,
    output fwk_pkg::fwk_alu_res_t      res
);
    import fwk_pkg::*;

    logic [DATA_W-1:0] sum;

    always_comb
    begin
        case (req.op)
            ALU_ADD: sum = req.a + req.b;
            ALU_SUB: sum = req.a - req.b;
            default: sum = req.a + req.b;
        endcase
    end

    // rank is never negative, so a negative sum is always below it
    assign res.sum        = sum;
    assign res.below_rank = sum[DATA_W-1] | (sum[RANK_W-1:0] < req.rank);

endmodule

`default_nettype wire

// ===== hdl/fenwick_tree_prefix_sum_kth.sv =====
// fenwick_tree_prefix_sum_kth: binary indexed tree over signed 32-bit counters
// depends on fwk_pkg, fwk_ram, fwk_alu
`default_nettype none

// A binary indexed tree over SIZE signed 32-bit partial sums held in one ram.
// Each input beat carries one action: add a delta at a position, return a
// prefix sum, return a closed range sum, or find the smallest position whose
// prefix sum reaches a rank (binary descent from bit LOG_SIZE down to bit 0).
// Sums wrap in two's complement. Every input beat gives exactly one result
// beat. After reset the ram is swept to zero, one entry a cycle, and the input
// side stays not ready until the sweep is done; cfg writes are taken at all
// times. One item at a time: each tree node takes a read state that issues the
// ram read and a second state that uses the registered read data in the shared
// adder. An add visits each node it touches; an ignored add goes straight to
// its result. A prefix sum visits the set bits of the clamped end, a range sum
// those of both clamped ends. Find by rank skips each out of range bit and
// probes the rest. A new item is taken while the previous result still waits
// in the output register.
module fenwick_tree_prefix_sum_kth #(
    parameter int SIZE     = 4096,
    parameter int LOG_SIZE = 12
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire fwk_pkg::fwk_item_t         item_data,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output fwk_pkg::fwk_result_t            result_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [fwk_pkg::POS_W-1:0]  cfg_data
);
    import fwk_pkg::*;

    // ram address, tree index and descent bit widths
    localparam int AW    = $clog2(SIZE);
    localparam int IDX_W = $clog2(SIZE + 1);
    localparam int CW_A  = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;
    localparam int CW    = (CW_A > LOG_SIZE + 2) ? CW_A : LOG_SIZE + 2;
    localparam int BW    = $clog2(LOG_SIZE + 1);
    localparam logic [POS_W-1:0] SIZE_RST =
        (SIZE > (2 ** POS_W) - 1) ? {POS_W{1'b1}} : POS_W'(SIZE);

    // control state
    fwk_state_t         state_reg, state_next;
    logic [POS_W-1:0]   active_size_reg;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               result_valid_reg, result_valid_next;

    // per-item working registers
    fwk_action_t        action_reg, action_next;
    logic [DATA_W-1:0]  delta_reg, delta_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      second_idx_reg, second_idx_next;
    logic               second_reg, second_next;
    logic               sub_reg, sub_next;
    logic [CW-1:0]      base_reg, base_next;
    logic [BW-1:0]      bit_reg, bit_next;
    fwk_result_t        result_reg, result_next;

    // ram and adder hookup
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    fwk_alu_req_t       alu_req;
    fwk_alu_res_t       alu_res;

    // derived values
    logic               item_fire;
    logic               result_free;
    logic [CW-1:0]      n_used;
    logic [CW-1:0]      act_ext;
    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      right_ext;
    logic [CW-1:0]      pos_m1;
    logic [CW-1:0]      low_bit;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      probe;
    logic [CW-1:0]      probe_m1;
    logic               probe_ok;
    logic               add_ok;

    assign item_fire   = item_valid & item_ready;
    assign result_free = ~result_valid_reg | result_ready;

    // sizes above SIZE act as SIZE
    assign act_ext   = CW'(active_size_reg);
    assign n_used    = (act_ext > CW'(SIZE)) ? CW'(SIZE) : act_ext;
    assign pos_ext   = CW'(item_data.position);
    assign right_ext = CW'(item_data.right_end);
    assign pos_m1    = pos_ext - CW'(1);
    assign add_ok    = (pos_ext != '0) && (pos_ext <= n_used);

    // lowest set bit of the walk index, and the descent probe
    assign low_bit  = idx_reg & (~idx_reg + CW'(1));
    assign idx_m1   = idx_reg - CW'(1);
    assign probe    = base_reg + (CW'(1) << bit_reg);
    assign probe_m1 = probe - CW'(1);
    assign probe_ok = probe <= n_used;

    fwk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fwk_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    case (item_data.action)
                        ACT_ADD:    state_next = add_ok ? ST_ADD_RD : ST_DONE;
                        ACT_PREFIX: state_next = ST_SUM_RD;
                        ACT_RANGE:  state_next = ST_SUM_RD;
                        default:    state_next = ST_FIND_RD;
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                state_next = (idx_reg <= n_used) ? ST_ADD_WR : ST_DONE;
            end
            ST_ADD_WR:
            begin
                state_next = ST_ADD_RD;
            end
            ST_SUM_RD:
            begin
                if (idx_reg != '0)
                begin
                    state_next = ST_SUM_ACC;
                end
                else if (!second_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SUM_ACC:
            begin
                state_next = ST_SUM_RD;
            end
            ST_FIND_RD:
            begin
                if (probe_ok)
                begin
                    state_next = ST_FIND_EVAL;
                end
                else if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIND_EVAL:
            begin
                state_next = (bit_reg == '0) ? ST_DONE : ST_FIND_RD;
            end
            ST_DONE:
            begin
                if (result_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshakes, ram port and adder operands
    always_comb
    begin
        item_ready   = (state_reg == ST_IDLE);
        cfg_ready    = 1'b1;
        ram_we       = 1'b0;
        ram_waddr    = idx_m1[AW-1:0];
        ram_wdata    = alu_res.sum;
        ram_raddr    = idx_m1[AW-1:0];
        alu_req.op   = ALU_ADD;
        alu_req.a    = acc_reg;
        alu_req.b    = ram_rdata;
        alu_req.rank = rank_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_ADD_WR:
            begin
                // read-modify-write of one node
                ram_we    = 1'b1;
                alu_req.a = delta_reg;
            end
            ST_SUM_ACC:
            begin
                alu_req.op = sub_reg ? ALU_SUB : ALU_ADD;
            end
            ST_FIND_RD:
            begin
                ram_raddr = probe_m1[AW-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // working register updates
    always_comb
    begin
        clr_next          = clr_reg;
        action_next       = action_reg;
        delta_next        = delta_reg;
        rank_next         = rank_reg;
        acc_next          = acc_reg;
        idx_next          = idx_reg;
        second_idx_next   = second_idx_reg;
        second_next       = second_reg;
        sub_next          = sub_reg;
        base_next         = base_reg;
        bit_next          = bit_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    action_next = item_data.action;
                    delta_next  = item_data.delta;
                    rank_next   = item_data.rank;
                    acc_next    = '0;
                    base_next   = '0;
                    bit_next    = BW'(LOG_SIZE);
                    sub_next    = 1'b0;
                    second_next = (item_data.action == ACT_RANGE);
                    // second walk ends at position-1, zero when position is zero
                    if (pos_ext == '0)
                    begin
                        second_idx_next = '0;
                    end
                    else
                    begin
                        second_idx_next = (pos_m1 > n_used) ? n_used : pos_m1;
                    end
                    case (item_data.action)
                        ACT_ADD:    idx_next = pos_ext;
                        ACT_RANGE:  idx_next = (right_ext > n_used) ? n_used : right_ext;
                        default:    idx_next = (pos_ext > n_used) ? n_used : pos_ext;
                    endcase
                end
            end
            ST_ADD_WR:
            begin
                idx_next = idx_reg + low_bit;
            end
            ST_SUM_RD:
            begin
                // first walk done: start the subtracting walk of a range sum
                if (idx_reg == '0 && second_reg)
                begin
                    idx_next    = second_idx_reg;
                    second_next = 1'b0;
                    sub_next    = 1'b1;
                end
            end
            ST_SUM_ACC:
            begin
                acc_next = alu_res.sum;
                idx_next = idx_reg - low_bit;
            end
            ST_FIND_RD:
            begin
                if (!probe_ok && bit_reg != '0)
                begin
                    bit_next = bit_reg - BW'(1);
                end
            end
            ST_FIND_EVAL:
            begin
                if (alu_res.below_rank)
                begin
                    base_next = probe;
                    acc_next  = alu_res.sum;
                end
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - BW'(1);
                end
            end
            ST_DONE:
            begin
                if (result_free)
                begin
                    result_valid_next = 1'b1;
                    if (action_reg == ACT_PREFIX || action_reg == ACT_RANGE)
                    begin
                        result_next.sum_value = $signed(acc_reg);
                    end
                    else
                    begin
                        result_next.sum_value = '0;
                    end
                    if (action_reg == ACT_FIND)
                    begin
                        result_next.found_position = base_reg[POS_W-1:0] + POS_W'(1);
                    end
                    else
                    begin
                        result_next.found_position = '0;
                    end
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
            active_size_reg  <= SIZE_RST;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_size_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        delta_reg      <= delta_next;
        rank_reg       <= rank_next;
        acc_reg        <= acc_next;
        idx_reg        <= idx_next;
        second_idx_reg <= second_idx_next;
        second_reg     <= second_next;
        sub_reg        <= sub_next;
        base_reg       <= base_next;
        bit_reg        <= bit_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // an add only ever writes nodes inside the active size
    a_add_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD_WR) |-> (idx_reg != '0 && idx_reg <= n_used))
        else $error("add writes a node outside the active size");

    // a sum walk only ever reads nodes inside the active size
    a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM_ACC) |-> (idx_reg != '0 && idx_reg <= n_used))
        else $error("sum walk reads a node outside the active size");

    // the descent only evaluates probes that were in range when issued
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND_EVAL) |-> probe_ok)
        else $error("descent evaluates an out of range probe");

    // an accepted beat always leaves idle
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg != ST_IDLE && state_reg != ST_CLEAR))
        else $error("accepted beat did not start work");

    // a result only appears when an item finishes
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside of item completion");

endmodule

`default_nettype wire

// ===== tb/fwk_tree_checker.sv =====
`timescale 1ns / 1ps
// fwk_tree_checker: scoreboard for the binary indexed tree block
// watches the cfg, item and result channels, predicts and compares each result beat
// depends on fwk_pkg

module fwk_tree_checker #(
    parameter int SIZE     = 4096,
    parameter int LOG_SIZE = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  fwk_pkg::fwk_item_t          item_data,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  fwk_pkg::fwk_result_t        result_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [fwk_pkg::POS_W-1:0]   cfg_data,
    output int                          mismatch_count,
    output int                          results_owed
);
    import fwk_pkg::*;

    localparam int MAX_PRINTED = 40;

    logic [DATA_W-1:0] node_sum [SIZE];
    logic [POS_W-1:0]  live_size;
    fwk_result_t       owed_results [$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // sizes above the store depth act as the full depth
    function automatic int used_positions();
        return (live_size > SIZE) ? SIZE : int'(live_size);
    endfunction

    function automatic logic [DATA_W-1:0] tree_prefix(input int upto);
        int                i;
        logic [DATA_W-1:0] acc;
        i   = (upto > used_positions()) ? used_positions() : upto;
        acc = '0;
        while (i > 0)
        begin
            acc += node_sum[i-1];
            i   -= i & -i;
        end
        return acc;
    endfunction

    function automatic void tree_add(input int pos, input logic [DATA_W-1:0] amount);
        int i;
        if (pos == 0 || pos > used_positions())
            return;
        for (i = pos; i <= used_positions(); i += i & -i)
            node_sum[i-1] += amount;
    endfunction

    // descent from the top bit, signed compare of the running sum
    function automatic logic [POS_W-1:0] tree_descend(input logic [RANK_W-1:0] target);
        int                base;
        int                probe;
        int                b;
        logic [DATA_W-1:0] run;
        logic [DATA_W-1:0] trial;
        base = 0;
        run  = '0;
        for (b = LOG_SIZE; b >= 0; b--)
        begin
            probe = base + (1 << b);
            if (probe <= used_positions())
            begin
                trial = run + node_sum[probe-1];
                if ($signed(trial) < $signed({1'b0, target}))
                begin
                    base = probe;
                    run  = trial;
                end
            end
        end
        return POS_W'(base + 1);
    endfunction

    function automatic fwk_result_t predict_result(input fwk_item_t it);
        fwk_result_t r;
        r = '0;
        case (it.action)
            ACT_ADD:
                tree_add(it.position, it.delta);
            ACT_PREFIX:
                r.sum_value = tree_prefix(it.position);
            ACT_RANGE:
            begin
                r.sum_value = tree_prefix(it.right_end);
                if (it.position != 0)
                    r.sum_value = r.sum_value - tree_prefix(int'(it.position) - 1);
            end
            default:
                r.found_position = tree_descend(it.rank);
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fwk_result_t owed;
        if (!rst_n)
        begin
            for (int k = 0; k < SIZE; k++)
                node_sum[k] = '0;
            live_size = POS_W'(SIZE);
            owed_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                live_size = cfg_data;
            if (item_valid && item_ready)
                owed_results.insert(owed_results.size(), predict_result(item_data));
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    owed = owed_results.pop_front();
                    if (result_data.sum_value !== owed.sum_value)
                        report_mismatch($sformatf("sum_value got %0d want %0d",
                                        result_data.sum_value, owed.sum_value));
                    if (result_data.found_position !== owed.found_position)
                        report_mismatch($sformatf("found_position got %0d want %0d",
                                        result_data.found_position, owed.found_position));
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

// ===== tb/tb_fenwick_tree_prefix_sum_kth.sv =====
`timescale 1ns / 1ps
// tb_fenwick_tree_prefix_sum_kth: stimulus and verdict for the binary indexed tree block
// drives the cfg, item and result channels; prediction lives in fwk_tree_checker
// depends on fwk_pkg, fwk_tree_checker and the block's rtl

module tb_fenwick_tree_prefix_sum_kth;
    import fwk_pkg::*;

    localparam int SIZE        = 4096;
    localparam int LOG_SIZE    = 12;
    localparam int PHASES      = 12;
    localparam int LONG_HOLD   = 400;    // receiver hold-off, far longer than one item
    localparam int DRAIN_LIMIT = 20000;  // cycles allowed for the last results to come out
    localparam int SETTLE      = 64;     // quiet cycles after the last result

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    fwk_item_t        item_data    = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    fwk_result_t      result_data;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [POS_W-1:0] cfg_data     = '0;

    int mismatch_count;
    int results_owed;

    int holds_asked  = 0;    // long receiver hold-offs requested by the stimulus
    int holds_done   = 0;    // and carried out by the receiver
    int gapless_left = 0;    // beats left in a back-to-back burst
    int rank_span    = 0;    // rough running total, keeps most ranks inside the tree
    bit stuck        = 1'b0;

    always #10 clk = ~clk;

    fenwick_tree_prefix_sum_kth #(
        .SIZE     (SIZE),
        .LOG_SIZE (LOG_SIZE)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    fwk_tree_checker #(
        .SIZE     (SIZE),
        .LOG_SIZE (LOG_SIZE)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item_data      (item_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // active size and beat count of each random phase; shrinks leave old
    // entries behind, zero and oversize settings are covered as well
    task automatic phase_plan(input int p, output int size, output int beats);
        case (p)
            0:       begin size = 4096; beats = 120; end
            1:       begin size = 1;    beats = 40;  end
            2:       begin size = 37;   beats = 90;  end
            3:       begin size = 2;    beats = 40;  end
            4:       begin size = 300;  beats = 90;  end
            5:       begin size = 4097; beats = 80;  end
            6:       begin size = 1000; beats = 100; end
            7:       begin size = 0;    beats = 30;  end
            8:       begin size = 16;   beats = 80;  end
            9:       begin size = 2048; beats = 100; end
            10:      begin size = 8191; beats = 120; end
            default: begin size = 7;    beats = 60;  end
        endcase
    endtask

    function automatic fwk_item_t mk_item(input fwk_action_t act, input int pos,
                                          input int right, input logic [DATA_W-1:0] amount,
                                          input logic [RANK_W-1:0] target);
        fwk_item_t it;
        it.action    = act;
        it.position  = POS_W'(pos);
        it.right_end = POS_W'(right);
        it.delta     = amount;
        it.rank      = target;
        return it;
    endfunction

    // position: mostly in range, some at zero or one past the end, some anywhere
    function automatic logic [POS_W-1:0] pick_pos(input int used);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return POS_W'($urandom_range(0, 8191));
        if (r < 9)
            return '0;
        if (r < 12 || used == 0)
            return POS_W'(used + 1);
        return POS_W'($urandom_range(1, used));
    endfunction

    // random item: small deltas keep the prefix sums ordered so the rank
    // descent goes deep; a few wild deltas and ranks exercise every bit
    function automatic fwk_item_t random_item(input int size);
        fwk_item_t it;
        int        used;
        used         = (size > SIZE) ? SIZE : size;
        it.action    = fwk_action_t'($urandom_range(0, 3));
        it.position  = pick_pos(used);
        it.right_end = pick_pos(used);
        if ($urandom_range(0, 19) == 0)
            it.delta = $urandom();
        else
            it.delta = int'($urandom_range(0, 60)) - 12;
        if ($urandom_range(0, 9) == 0)
            it.rank = RANK_W'($urandom());
        else
            it.rank = RANK_W'($urandom_range(0, rank_span + 4));
        if (it.action == ACT_ADD && it.position >= 1 && it.position <= used
            && $signed(it.delta) > -100 && $signed(it.delta) < 100)
        begin
            rank_span += int'($signed(it.delta));
            if (rank_span < 0)
                rank_span = 0;
        end
        return it;
    endfunction

    // offer one item beat, with a random gap first unless in a burst; valid
    // stays high straight into the next beat when there is no gap
    task automatic drive_item(input fwk_item_t beat);
        int gap;
        if (gapless_left > 0)
        begin
            gapless_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 29) == 0)
                gapless_left = $urandom_range(15, 40);
            gap = pick_idle();
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= beat;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // block is idle once every expected result beat has been taken
    task automatic wait_quiet();
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_cfg(input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls and ready runs, some long ready stretches,
    // and a long hold-off whenever the stimulus asks for one
    initial
    begin
        int stall;
        int run;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_done < holds_asked)
            begin
                // items keep coming, so the block fills and drops item_ready
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                stall = pick_idle();
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ready <= 1'b1;
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 8);
                repeat (run) @(posedge clk);
            end
        end
    end

    // hard stop for a hung run
    initial
    begin
        #20_000_000;
        $display("** fenwick_tree_prefix_sum_kth: FAILED **");
        $finish;
    end

    initial
    begin
        int size;
        int beats;
        int waited;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the ram sweep after reset holds item_ready low for a while;
        // cfg beats are taken during the sweep
        write_cfg(POS_W'(SIZE));

        // full size: extremes of delta and position, ignored adds, saturated ends
        drive_item(mk_item(ACT_ADD,    1,    0,    32'd5,          '0));
        drive_item(mk_item(ACT_ADD,    4096, 0,    32'h7FFF_FFFF,  '0));
        drive_item(mk_item(ACT_ADD,    2048, 0,    32'h8000_0000,  '0));
        drive_item(mk_item(ACT_ADD,    0,    0,    32'd9,          '0));  // position zero
        drive_item(mk_item(ACT_ADD,    4097, 0,    32'd3,          '0));  // past the end
        drive_item(mk_item(ACT_ADD,    8191, 8191, 32'hFFFF_FFFF,  '1));  // all ones
        drive_item(mk_item(ACT_PREFIX, 0,    0,    '0,             '0));
        drive_item(mk_item(ACT_PREFIX, 4096, 0,    '0,             '0));
        drive_item(mk_item(ACT_PREFIX, 8191, 0,    '0,             '0));  // end saturates
        drive_item(mk_item(ACT_RANGE,  1,    4096, '0,             '0));
        drive_item(mk_item(ACT_RANGE,  0,    2047, '0,             '0));  // left end zero
        drive_item(mk_item(ACT_RANGE,  4096, 1,    '0,             '0));  // reversed range
        drive_item(mk_item(ACT_RANGE,  8191, 8191, '0,             '0));
        drive_item(mk_item(ACT_FIND,   0,    0,    '0,             '0));
        drive_item(mk_item(ACT_FIND,   0,    0,    '0,             '1));  // largest rank
        drive_item(mk_item(ACT_FIND,   0,    0,    '0,             31'd5));
        drive_item(mk_item(ACT_FIND,   0,    0,    '0,             31'd6));
        item_valid <= 1'b0;

        // size zero: nothing in use, descent answers one
        wait_quiet();
        write_cfg('0);
        drive_item(mk_item(ACT_ADD,    1, 0, 32'd7, '0));
        drive_item(mk_item(ACT_PREFIX, 3, 0, '0,    '0));
        drive_item(mk_item(ACT_RANGE,  0, 5, '0,    '0));
        drive_item(mk_item(ACT_FIND,   0, 0, '0,    31'd3));
        item_valid <= 1'b0;

        // oversize acts as full size; these adds cancel the extreme deltas
        wait_quiet();
        write_cfg('1);
        drive_item(mk_item(ACT_ADD,    4096, 0, 32'h8000_0001, '0));
        drive_item(mk_item(ACT_ADD,    2048, 0, 32'h8000_0000, '0));
        drive_item(mk_item(ACT_FIND,   0,    0, '0,            31'd1));
        drive_item(mk_item(ACT_PREFIX, 8191, 0, '0,            '0));
        item_valid <= 1'b0;
        rank_span = 5;

        // random phases, each under its own active size
        for (int p = 0; p < PHASES; p++)
        begin
            phase_plan(p, size, beats);
            wait_quiet();
            write_cfg(POS_W'(size));
            if (p == 2 || p == 9)
                holds_asked++;
            repeat (beats) drive_item(random_item(size));
            item_valid <= 1'b0;
        end

        // drain, bounded, then a few quiet cycles to catch stray result beats
        waited = 0;
        @(negedge clk);
        while (results_owed != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        stuck = (results_owed != 0);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0 && !stuck)
            $display("** fenwick_tree_prefix_sum_kth: PASSED **");
        else
            $display("** fenwick_tree_prefix_sum_kth: FAILED **");
        $finish;
    end

endmodule
